@@ sv/kbt_pkg.sv @@
// Shared types, constants and key hashing for the keyed balance table.
`default_nettype none

package kbt_pkg;

    // Table geometry and payload widths
    localparam int ENTRIES     = 256;
    localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AMOUNT_BITS = 48;

    localparam int OP_W  = 2;
    localparam int ACC_W = 32;
    localparam int CUR_W = 16;
    localparam int AMT_W = 48;
    localparam int ST_W  = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CREDIT = 2'd0;
    localparam logic [OP_W-1:0] OP_DEBIT  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FUNDS    = 3'd1;
    localparam logic [ST_W-1:0] ST_MISSING  = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;

    typedef logic [IDX_BITS-1:0]    idx_t;
    typedef logic [AMOUNT_BITS-1:0] amount_t;

    // One stored slot
    typedef struct packed {
        logic [ACC_W-1:0] account;
        logic [CUR_W-1:0] currency;
        amount_t          amount;
    } entry_t;

    // Write request into the store
    typedef struct packed {
        logic   en;
        idx_t   addr;
        entry_t data;
    } wr_req_t;

    // Fold the key into a home slot: xor the key bits onto the index bits
    function automatic idx_t key_hash(input logic [ACC_W-1:0] acc,
                                      input logic [CUR_W-1:0] cur);
        logic [IDX_BITS-1:0]    h;
        logic [ACC_W+CUR_W-1:0] key;
        h   = '0;
        key = {acc, cur};
        for (int i = 0; i < ACC_W + CUR_W; i++) begin
            h[i % IDX_BITS] = h[i % IDX_BITS] ^ key[i];
        end
        if (int'(h) >= ENTRIES) begin
            h = IDX_BITS'(int'(h) - ENTRIES);
        end
        return h;
    endfunction

    // Next probe slot, wrapping at the end of the table
    function automatic idx_t next_slot(input idx_t idx);
        idx_t n;
        if (int'(idx) == ENTRIES - 1) begin
            n = '0;
        end
        else begin
            n = idx + IDX_BITS'(1);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ sv/kbt_ifs.sv @@
// Request and response channel interfaces of the keyed balance table.
`default_nettype none

interface kbt_req_if;
    logic                     valid;
    logic                     ready;
    logic [kbt_pkg::OP_W-1:0]  op;
    logic [kbt_pkg::ACC_W-1:0] account;
    logic [kbt_pkg::CUR_W-1:0] currency;
    logic [kbt_pkg::AMT_W-1:0] amount;

    modport source (output valid, output op, output account, output currency,
                    output amount, input ready);
    modport sink   (input valid, input op, input account, input currency,
                    input amount, output ready);
endinterface

interface kbt_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [kbt_pkg::ST_W-1:0]  status;
    logic [kbt_pkg::AMT_W-1:0] balance_out;

    modport source (output valid, output status, output balance_out, input ready);
    modport sink   (input valid, input status, input balance_out, output ready);
endinterface

`default_nettype wire

@@ sv/kbt_store.sv @@
// Slot memory with one registered read port, one write port and per-slot valid bits.
`default_nettype none

module kbt_store (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire kbt_pkg::idx_t    rd_addr,
    input  wire kbt_pkg::wr_req_t wr,
    output logic                  rd_valid,
    output kbt_pkg::entry_t       rd_entry
);
    import kbt_pkg::*;

    entry_t             mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic               rd_valid_reg;
    entry_t             rd_entry_reg;

    // Write the slot, read one slot a cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    // Mark written slots, clear all marks at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

@@ sv/keyed_balance_table.sv @@
// Top level of the keyed balance table: probe sequencer, update logic and result register.
`default_nettype none

// Balances keyed by (account, currency) live in a single-port-read slot memory
// of ENTRIES slots, placed by hashing the key and probing linearly. One item
// is handled at a time: the item is taken in the idle state, which issues the
// home slot read; the probe state then checks the probed slots one at a time,
// as the memory gives one read a cycle; the exec state updates the slot and
// loads the result register. An item whose key sits in its home slot, or whose
// home slot is free, needs only the home slot probe; up to ENTRIES slots are
// probed on a nearly full table. The result register lets the next item be taken while a
// result still waits; an update waits only if the previous result is untaken.
// The slot valid marks are flip-flops cleared by reset, so no clearing pass is
// needed and the first item may follow reset at once.
module keyed_balance_table (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kbt_req_if.sink    req,
    kbt_rsp_if.source  rsp
);
    import kbt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]       state_reg,  state_next;
    idx_t             idx_reg,    idx_next;
    idx_t             cnt_reg,    cnt_next;
    logic [OP_W-1:0]  op_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [CUR_W-1:0] cur_reg;
    amount_t          amt_reg;
    logic             found_reg,  found_next;
    logic             full_reg,   full_next;
    amount_t          old_reg,    old_next;

    logic             rsp_valid_reg;
    logic [ST_W-1:0]  rsp_status_reg;
    logic [AMT_W-1:0] rsp_bal_reg;

    idx_t             rd_addr;
    logic             rd_valid;
    entry_t           rd_entry;
    wr_req_t          wr_req;

    logic             accept;
    logic             key_match;
    logic             slot_empty;
    logic             last_probe;
    logic             can_emit;
    logic [AMOUNT_BITS:0] sum;
    logic [AMOUNT_BITS:0] diff;
    logic [ST_W-1:0]  status_c;
    amount_t          bal_c;
    logic             write_c;

    kbt_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .wr       (wr_req),
        .rd_valid (rd_valid),
        .rd_entry (rd_entry)
    );

    // Take a new item only when idle
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign can_emit  = !rsp_valid_reg || rsp.ready;

    // Issue the home slot read on acceptance, else the next probe slot
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd_addr = key_hash(req.account, req.currency);
        end
        else
        begin
            rd_addr = next_slot(idx_reg);
        end
    end

    // Classify the slot just read
    assign key_match  = rd_valid && (rd_entry.account == acc_reg)
                        && (rd_entry.currency == cur_reg);
    assign slot_empty = !rd_valid;
    assign last_probe = (int'(cnt_reg) == ENTRIES - 1);

    // Sequence the probes
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        full_next  = full_reg;
        old_next   = old_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PROBE;
                    idx_next   = rd_addr;
                    cnt_next   = '0;
                end
            end
            S_PROBE:
            begin
                if (key_match || slot_empty || last_probe)
                begin
                    state_next = S_EXEC;
                    found_next = key_match;
                    full_next  = !key_match && !slot_empty;
                    old_next   = rd_entry.amount;
                end
                else
                begin
                    idx_next = rd_addr;
                    cnt_next = cnt_reg + IDX_BITS'(1);
                end
            end
            S_EXEC:
            begin
                if (can_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Work out the new balance and status
    assign sum  = {1'b0, old_reg} + {1'b0, amt_reg};
    assign diff = {1'b0, old_reg} - {1'b0, amt_reg};

    always_comb
    begin
        status_c = ST_OK;
        bal_c    = '0;
        write_c  = 1'b0;
        case (op_reg)
            OP_CREDIT:
            begin
                if (found_reg)
                begin
                    if (sum[AMOUNT_BITS])
                    begin
                        status_c = ST_OVERFLOW;
                    end
                    else
                    begin
                        bal_c   = sum[AMOUNT_BITS-1:0];
                        write_c = 1'b1;
                    end
                end
                else if (full_reg)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    bal_c   = amt_reg;
                    write_c = 1'b1;
                end
            end
            OP_DEBIT:
            begin
                if (!found_reg)
                begin
                    status_c = ST_MISSING;
                end
                else if (diff[AMOUNT_BITS])
                begin
                    status_c = ST_FUNDS;
                end
                else
                begin
                    bal_c   = diff[AMOUNT_BITS-1:0];
                    write_c = 1'b1;
                end
            end
            default:
            begin
                if (found_reg)
                begin
                    bal_c = old_reg;
                end
            end
        endcase
    end

    // Write back the slot when the result is emitted
    assign wr_req.en            = (state_reg == S_EXEC) && can_emit && write_c;
    assign wr_req.addr          = idx_reg;
    assign wr_req.data.account  = acc_reg;
    assign wr_req.data.currency = cur_reg;
    assign wr_req.data.amount   = bal_c;

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_EXEC) && can_emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the item and probe payload
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        cnt_reg   <= cnt_next;
        found_reg <= found_next;
        full_reg  <= full_next;
        old_reg   <= old_next;
        if (accept)
        begin
            op_reg  <= req.op;
            acc_reg <= req.account;
            cur_reg <= req.currency;
            amt_reg <= AMOUNT_BITS'(req.amount);
        end
        if ((state_reg == S_EXEC) && can_emit)
        begin
            rsp_status_reg <= status_c;
            rsp_bal_reg    <= AMT_W'(bal_c);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.balance_out = rsp_bal_reg;

`ifndef SYNTHESIS
    // An accepted item always starts probing
    a_accept_probe: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_PROBE))
        else $error("accepted item did not start probing");

    // A written slot carries the balance that is reported
    a_write_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_req.en |=> (rsp.valid && (rsp.status == ST_OK)
                       && (rsp.balance_out == AMT_W'($past(wr_req.data.amount)))))
        else $error("stored balance differs from reported balance");

    // A rejected item reports a zero balance
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.balance_out == '0))
        else $error("rejected item reported a nonzero balance");

    // A slot is written while a result waits only when that result is being taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_req.en && rsp_valid_reg) |-> rsp.ready)
        else $error("slot written while previous result untaken");
`endif

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the keyed balance table: scoreboard class, drivers and top module.
`timescale 1ns / 100ps

typedef struct packed {
    logic [kbt_pkg::OP_W-1:0]  op;
    logic [kbt_pkg::ACC_W-1:0] account;
    logic [kbt_pkg::CUR_W-1:0] currency;
    kbt_pkg::amount_t          amount;
} request_t;

typedef struct packed {
    logic [kbt_pkg::ST_W-1:0] status;
    kbt_pkg::amount_t         balance;
} outcome_t;

// Shadow copy of the balance table plus the queue of outcomes still owed by the block
class ledger_board;
    bit                        slot_used [kbt_pkg::ENTRIES];
    logic [kbt_pkg::ACC_W-1:0] slot_acc  [kbt_pkg::ENTRIES];
    logic [kbt_pkg::CUR_W-1:0] slot_cur  [kbt_pkg::ENTRIES];
    kbt_pkg::amount_t          slot_bal  [kbt_pkg::ENTRIES];
    outcome_t                  due_outcomes [$];
    int                        mismatches;
    int                        requests_seen;
    int                        results_seen;
    int                        status_tally [8];

    function new();
        mismatches    = 0;
        requests_seen = 0;
        results_seen  = 0;
        foreach (slot_used[i])
        begin
            slot_used[i] = 1'b0;
        end
        foreach (status_tally[i])
        begin
            status_tally[i] = 0;
        end
    endfunction

    function int find_key(input logic [kbt_pkg::ACC_W-1:0] acc,
                          input logic [kbt_pkg::CUR_W-1:0] cur);
        for (int i = 0; i < kbt_pkg::ENTRIES; i++)
        begin
            if (slot_used[i] && slot_acc[i] == acc && slot_cur[i] == cur)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function int lowest_free();
        for (int i = 0; i < kbt_pkg::ENTRIES; i++)
        begin
            if (!slot_used[i])
            begin
                return i;
            end
        end
        return -1;
    endfunction

    // Current balance of a key; zero and a clear return when the key is absent
    function bit lookup(input logic [kbt_pkg::ACC_W-1:0] acc,
                        input logic [kbt_pkg::CUR_W-1:0] cur,
                        output kbt_pkg::amount_t bal);
        int s;
        s   = find_key(acc, cur);
        bal = (s < 0) ? '0 : slot_bal[s];
        return (s >= 0);
    endfunction

    function int occupied();
        int n;
        n = 0;
        foreach (slot_used[i])
        begin
            n += slot_used[i];
        end
        return n;
    endfunction

    function int pending();
        return due_outcomes.size();
    endfunction

    // Apply an accepted request to the shadow table and queue the outcome it must give
    function void post_request(input request_t r);
        outcome_t         o;
        int               s;
        int               f;
        kbt_pkg::amount_t old;
        o.status = kbt_pkg::ST_OK;
        o.balance = '0;
        s = find_key(r.account, r.currency);
        case (r.op)
            kbt_pkg::OP_CREDIT:
            begin
                if (s < 0)
                begin
                    f = lowest_free();
                    if (f < 0)
                    begin
                        o.status = kbt_pkg::ST_FULL;
                    end
                    else
                    begin
                        slot_used[f] = 1'b1;
                        slot_acc[f]  = r.account;
                        slot_cur[f]  = r.currency;
                        slot_bal[f]  = r.amount;
                        o.balance    = r.amount;
                    end
                end
                else
                begin
                    old = slot_bal[s];
                    if (r.amount > ('1 - old))
                    begin
                        o.status = kbt_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        slot_bal[s] = old + r.amount;
                        o.balance   = old + r.amount;
                    end
                end
            end
            kbt_pkg::OP_DEBIT:
            begin
                if (s < 0)
                begin
                    o.status = kbt_pkg::ST_MISSING;
                end
                else if (slot_bal[s] < r.amount)
                begin
                    o.status = kbt_pkg::ST_FUNDS;
                end
                else
                begin
                    slot_bal[s] = slot_bal[s] - r.amount;
                    o.balance   = slot_bal[s];
                end
            end
            // read and the unused selector both just report the balance
            default:
            begin
                if (s >= 0)
                begin
                    o.balance = slot_bal[s];
                end
            end
        endcase
        due_outcomes.push_back(o);
        status_tally[o.status]++;
        requests_seen++;
    endfunction

    // Compare one delivered result against the oldest outstanding outcome
    function void match_response(input logic [kbt_pkg::ST_W-1:0] status,
                                 input kbt_pkg::amount_t balance);
        outcome_t o;
        results_seen++;
        if (due_outcomes.size() == 0)
        begin
            $error("unexpected result: status %0d balance_out 0x%0h", status, balance);
            mismatches++;
        end
        else
        begin
            o = due_outcomes.pop_front();
            if (status !== o.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", o.status, status);
                mismatches++;
            end
            if (balance !== o.balance)
            begin
                $error("balance_out mismatch: expected 0x%0h, actual 0x%0h",
                       o.balance, balance);
                mismatches++;
            end
        end
    endfunction
endclass

module tb;

    localparam logic [kbt_pkg::OP_W-1:0] OP_SPARE   = 2'd3;
    localparam int                       POOL_MAX   = 48;
    localparam int                       LONG_HOLD  = 150;
    localparam int                       TAIL_WAIT  = kbt_pkg::ENTRIES + 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    kbt_req_if req_ch ();
    kbt_rsp_if rsp_ch ();

    keyed_balance_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ledger_board               ledger = new();
    logic [kbt_pkg::ACC_W-1:0] pool_acc [$];
    logic [kbt_pkg::CUR_W-1:0] pool_cur [$];
    int                        sender_calm = 0;

    // Free-running clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #25_000_000;
        $display("simulation failed");
        $finish;
    end

    // Idle length for one item: drawn uniformly at random, with occasional runs of back-to-back items
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic kbt_pkg::amount_t wide_random();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[kbt_pkg::AMT_W-1:0];
    endfunction

    function automatic request_t mk(input logic [kbt_pkg::OP_W-1:0] op,
                                    input logic [kbt_pkg::ACC_W-1:0] acc,
                                    input logic [kbt_pkg::CUR_W-1:0] cur,
                                    input kbt_pkg::amount_t amt);
        request_t r;
        r.op       = op;
        r.account  = acc;
        r.currency = cur;
        r.amount   = amt;
        return r;
    endfunction

    // Keep a bounded pool of keys so that most traffic hits live entries
    function automatic void remember_key(input logic [kbt_pkg::ACC_W-1:0] acc,
                                         input logic [kbt_pkg::CUR_W-1:0] cur);
        int k;
        if (pool_acc.size() < POOL_MAX)
        begin
            pool_acc.push_back(acc);
            pool_cur.push_back(cur);
        end
        else
        begin
            k = $urandom_range(0, POOL_MAX - 1);
            pool_acc[k] = acc;
            pool_cur[k] = cur;
        end
    endfunction

    // Build one random request, steering amounts around the live balance
    task automatic pick_request(input int fresh_pct, output request_t r);
        int               roll;
        bit               fresh;
        int               k;
        kbt_pkg::amount_t bal;
        kbt_pkg::amount_t headroom;
        logic [63:0]      w;
        logic [63:0]      span;
        fresh = (pool_acc.size() == 0) || ($urandom_range(0, 99) < fresh_pct);
        if (fresh)
        begin
            r.account  = $urandom;
            r.currency = 16'($urandom);
        end
        else
        begin
            k = $urandom_range(0, pool_acc.size() - 1);
            r.account  = pool_acc[k];
            r.currency = pool_cur[k];
        end
        roll = $urandom_range(0, 99);
        if (roll < 40)
            r.op = kbt_pkg::OP_CREDIT;
        else if (roll < 75)
            r.op = kbt_pkg::OP_DEBIT;
        else if (roll < 92)
            r.op = kbt_pkg::OP_READ;
        else
            r.op = OP_SPARE;
        void'(ledger.lookup(r.account, r.currency, bal));
        headroom = '1 - bal;
        roll = $urandom_range(0, 99);
        case (r.op)
            kbt_pkg::OP_CREDIT:
            begin
                if (roll < 45)
                    r.amount = kbt_pkg::amount_t'($urandom_range(0, 5000));
                else if (roll < 70)
                    r.amount = wide_random() >> $urandom_range(0, 47);
                else if (roll < 85)
                    r.amount = headroom;
                else
                    r.amount = headroom + 1'b1;
            end
            kbt_pkg::OP_DEBIT:
            begin
                if (roll < 50)
                begin
                    w    = {$urandom, $urandom};
                    span = {16'd0, bal} + 64'd1;
                    w    = w % span;
                    r.amount = w[kbt_pkg::AMT_W-1:0];
                end
                else if (roll < 65)
                    r.amount = bal;
                else if (roll < 80)
                    r.amount = bal + 1'b1;
                else
                    r.amount = wide_random() >> $urandom_range(0, 47);
            end
            default:
            begin
                r.amount = wide_random();
            end
        endcase
        if (fresh && r.op == kbt_pkg::OP_CREDIT)
        begin
            remember_key(r.account, r.currency);
        end
    endtask

    // Offer one item after a random gap and hold it until the block takes it
    task automatic send_request(input request_t r);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= r.op;
        req_ch.account  <= r.account;
        req_ch.currency <= r.currency;
        req_ch.amount   <= r.amount;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        ledger.post_request(r);
    endtask

    task automatic wait_drained();
        while (ledger.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Result side: random back-pressure, two long hold-offs, check every item taken
    initial
    begin : result_sink
        int hold;
        int taken;
        int calm;
        hold  = 0;
        taken = 0;
        calm  = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                ledger.match_response(rsp_ch.status, rsp_ch.balance_out);
                taken++;
                if (taken == 300 || taken == 1200)
                    hold = LONG_HOLD;
                else
                    hold = draw_wait(calm);
            end
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus: directed corner cases, random traffic, table fill, traffic on a full table
    initial
    begin : request_source
        request_t         r;
        request_t         corner [$];
        kbt_pkg::amount_t top;
        kbt_pkg::amount_t alt_a;
        kbt_pkg::amount_t alt_5;
        top   = '1;
        alt_a = {(kbt_pkg::AMT_W / 2){2'b10}};
        alt_5 = {(kbt_pkg::AMT_W / 2){2'b01}};
        req_ch.valid    <= 1'b0;
        req_ch.op       <= kbt_pkg::OP_READ;
        req_ch.account  <= '0;
        req_ch.currency <= '0;
        req_ch.amount   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // read and debit of a missing key, zero credit creating an entry
        corner.push_back(mk(kbt_pkg::OP_READ,   32'h0,        16'h0,    '0));
        corner.push_back(mk(kbt_pkg::OP_DEBIT,  32'h0,        16'h0,    48'd5));
        corner.push_back(mk(kbt_pkg::OP_CREDIT, 32'hFFFF_FFFF, 16'hFFFF, '0));
        corner.push_back(mk(kbt_pkg::OP_READ,   32'hFFFF_FFFF, 16'hFFFF, top));
        // full-scale balance, overflow by one, zero credit at the top, drain to zero
        corner.push_back(mk(kbt_pkg::OP_CREDIT, 32'h0,        16'h0,    top));
        corner.push_back(mk(kbt_pkg::OP_CREDIT, 32'h0,        16'h0,    48'd1));
        corner.push_back(mk(kbt_pkg::OP_CREDIT, 32'h0,        16'h0,    '0));
        corner.push_back(mk(OP_SPARE,           32'h0,        16'h0,    48'd123));
        corner.push_back(mk(kbt_pkg::OP_DEBIT,  32'h0,        16'h0,    top));
        corner.push_back(mk(kbt_pkg::OP_DEBIT,  32'h0,        16'h0,    48'd1));
        // alternating patterns summing exactly to full scale
        corner.push_back(mk(kbt_pkg::OP_CREDIT, 32'hAAAA_AAAA, 16'h5555, alt_5));
        corner.push_back(mk(kbt_pkg::OP_CREDIT, 32'hAAAA_AAAA, 16'h5555, alt_a));
        corner.push_back(mk(kbt_pkg::OP_CREDIT, 32'hAAAA_AAAA, 16'h5555, 48'd1));
        corner.push_back(mk(kbt_pkg::OP_DEBIT,  32'hAAAA_AAAA, 16'h5555, top));
        corner.push_back(mk(kbt_pkg::OP_CREDIT, 32'h5555_5555, 16'hAAAA, alt_a));
        corner.push_back(mk(kbt_pkg::OP_DEBIT,  32'h5555_5555, 16'hAAAA, alt_a + 1'b1));
        corner.push_back(mk(kbt_pkg::OP_DEBIT,  32'h5555_5555, 16'hAAAA, 48'd1));
        corner.push_back(mk(OP_SPARE,           32'h5555_5555, 16'hAAAA, alt_5));
        // keys that differ from a live one in a single field
        corner.push_back(mk(kbt_pkg::OP_READ,   32'h0,        16'hFFFF, '0));
        corner.push_back(mk(kbt_pkg::OP_DEBIT,  32'hFFFF_FFFF, 16'h0,    '0));
        foreach (corner[i])
        begin
            send_request(corner[i]);
        end
        remember_key(32'h0, 16'h0);
        remember_key(32'hFFFF_FFFF, 16'hFFFF);
        remember_key(32'hAAAA_AAAA, 16'h5555);
        remember_key(32'h5555_5555, 16'hAAAA);

        // mostly live keys, a trickle of new ones
        for (int i = 0; i < 1000; i++)
        begin
            if (i == 500)
            begin
                req_ch.valid <= 1'b0;
                wait_drained();
            end
            pick_request(8, r);
            send_request(r);
        end
        req_ch.valid <= 1'b0;
        wait_drained();

        // fill every free slot with new keys
        while (ledger.occupied() < kbt_pkg::ENTRIES)
        begin
            r.op       = kbt_pkg::OP_CREDIT;
            r.account  = $urandom;
            r.currency = 16'($urandom);
            r.amount   = wide_random() >> $urandom_range(8, 47);
            send_request(r);
        end

        // full table: new keys are refused, live ones keep working
        for (int i = 0; i < 200; i++)
        begin
            pick_request(30, r);
            send_request(r);
        end
        req_ch.valid <= 1'b0;

        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        $display("covered %0d requests and %0d results, table holding %0d of %0d keys",
                 ledger.requests_seen, ledger.results_seen, ledger.occupied(),
                 kbt_pkg::ENTRIES);
        $display("outcomes: ok %0d, short funds %0d, missing %0d, full %0d, overflow %0d",
                 ledger.status_tally[kbt_pkg::ST_OK], ledger.status_tally[kbt_pkg::ST_FUNDS],
                 ledger.status_tally[kbt_pkg::ST_MISSING], ledger.status_tally[kbt_pkg::ST_FULL],
                 ledger.status_tally[kbt_pkg::ST_OVERFLOW]);
        if (ledger.mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
